[hdl/modular_exponentiation_core_macros.svh]
// Assertion macros shared by the modular exponentiation modules.
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define MX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define MX_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/modexp_pkg.sv]
// ----------------------------------------------------------------------------
// modexp_pkg
// Types and constants shared by the modular exponentiation core.
// ----------------------------------------------------------------------------
package modexp_pkg;

    // Width of every field on the ports.
    localparam int FIELD_WIDTH = 32;

    // Status of the modular multiplier as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } mul_status_t;

endpackage

[hdl/modexp_mulmod.sv]
// ----------------------------------------------------------------------------
// modexp_mulmod
// Interleaved shift-and-add modular multiplier: p = a * b mod n, taking one
// bit of a per cycle from the top. Requires b < n; a may be any value.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_core_macros.svh"

module modexp_mulmod
    import modexp_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] a_in,
    input  logic [WIDTH-1:0] b_in,
    input  logic [WIDTH-1:0] n_in,
    output logic [WIDTH-1:0] product,
    output mul_status_t      status
);

    localparam int XW = WIDTH + 3;
    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [CW-1:0] LAST_BIT = CW'(WIDTH - 1);

    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] p_reg;
    logic [WIDTH-1:0] p_next;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [XW-1:0] sum;
    logic [XW-1:0] diff1;
    logic [XW-1:0] diff2;

    // 2p + b stays below 3n, so at most two subtractions of n are needed.
    always_comb begin
        sum   = {2'b00, p_reg, 1'b0} + {3'b000, (a_reg[WIDTH-1] ? b_reg : '0)};
        diff1 = sum - {3'b000, n_in};
        diff2 = sum - {2'b00, n_in, 1'b0};
        if (!diff2[XW-1]) begin
            p_next = diff2[WIDTH-1:0];
        end else if (!diff1[XW-1]) begin
            p_next = diff1[WIDTH-1:0];
        end else begin
            p_next = sum[WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                a_reg    <= a_in;
                b_reg    <= b_in;
                p_reg    <= '0;
            end else if (busy_reg) begin
                p_reg   <= p_next;
                a_reg   <= a_reg << 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_BIT) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign product     = p_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    `MX_ASSERT_IMP(a_no_restart, aclk, aresetn, start, !busy_reg)
    `MX_ASSERT_IMP(a_product_reduced, aclk, aresetn, done_reg, p_reg < n_in)
    `MX_ASSERT_NXT(a_done_pulse, aclk, aresetn, done_reg, !done_reg && !busy_reg)

endmodule

[hdl/modular_exponentiation_core.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Computes base ^ exponent mod modulus by right-to-left square-and-multiply
// over a bit-serial modular multiplier.
//
//   Channel | Ports                                      | Direction
//   s_      | s_base_value, s_exponent, s_modulus        | in, one word per job
//   m_      | m_power_result                             | out, one word per job
//
// After acceptance, the one shared multiplier first reduces the base; then
// for each exponent bit it multiplies into the accumulator if the bit is
// set, and squares for every bit but the last. A zero modulus skips the
// multiplier and goes straight to the finish state, which loads the output
// register. Reset is synchronous and returns the sequencer to idle. A new
// word is taken as soon as the sequencer is idle, even while the previous
// result still waits; a result stalls the sequencer only when the output
// register is still full.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_core_macros.svh"

module modular_exponentiation_core
    import modexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [FIELD_WIDTH-1:0] s_base_value,
    input  logic [FIELD_WIDTH-1:0] s_exponent,
    input  logic [FIELD_WIDTH-1:0] s_modulus,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [FIELD_WIDTH-1:0] m_power_result
);

    localparam int W  = OPERAND_WIDTH;
    localparam int IW = (W > 1) ? $clog2(W) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_MUL_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_ACC,
        OP_SQUARE
    } mul_op_t;

    state_t  state_reg;
    mul_op_t op_reg;

    logic [W-1:0]  exp_reg;
    logic [W-1:0]  n_reg;
    logic [W-1:0]  acc_reg;
    logic [W-1:0]  sq_reg;
    logic [W-1:0]  res_reg;
    logic [IW-1:0] idx_reg;
    logic [W-1:0]  mul_a_reg;
    logic [W-1:0]  mul_b_reg;
    logic          mul_start_reg;
    logic          m_valid_reg;
    logic [FIELD_WIDTH-1:0] m_power_result_reg;

    logic [W-1:0] one_mod_n;
    logic [W-1:0] in_modulus;
    logic [W-1:0] mul_product;
    logic         out_free;
    logic         last_bit;
    mul_status_t  mul_status;

    assign in_modulus = s_modulus[W-1:0];
    assign one_mod_n  = W'(in_modulus != W'(1));
    assign out_free   = !m_valid_reg || m_ready;
    assign last_bit   = (idx_reg == LAST_IDX);

    modexp_mulmod #(
        .WIDTH (W)
    ) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .a_in    (mul_a_reg),
        .b_in    (mul_b_reg),
        .n_in    (n_reg),
        .product (mul_product),
        .status  (mul_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_REDUCE;
            mul_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            idx_reg       <= '0;
        end else begin
            mul_start_reg <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        exp_reg <= s_exponent[W-1:0];
                        n_reg   <= in_modulus;
                        acc_reg <= one_mod_n;
                        idx_reg <= '0;
                        if (in_modulus == '0) begin
                            // No reduction is possible; the answer is zero.
                            res_reg   <= '0;
                            state_reg <= ST_FINISH;
                        end else begin
                            // Base times (1 mod n) reduces the base.
                            mul_a_reg     <= s_base_value[W-1:0];
                            mul_b_reg     <= one_mod_n;
                            mul_start_reg <= 1'b1;
                            op_reg        <= OP_REDUCE;
                            state_reg     <= ST_MUL_WAIT;
                        end
                    end
                end
                ST_STEP: begin
                    if (exp_reg[0]) begin
                        mul_a_reg     <= acc_reg;
                        mul_b_reg     <= sq_reg;
                        mul_start_reg <= 1'b1;
                        op_reg        <= OP_ACC;
                        state_reg     <= ST_MUL_WAIT;
                    end else if (last_bit) begin
                        res_reg   <= acc_reg;
                        state_reg <= ST_FINISH;
                    end else begin
                        mul_a_reg     <= sq_reg;
                        mul_b_reg     <= sq_reg;
                        mul_start_reg <= 1'b1;
                        op_reg        <= OP_SQUARE;
                        state_reg     <= ST_MUL_WAIT;
                    end
                end
                ST_MUL_WAIT: begin
                    if (mul_status.done) begin
                        unique case (op_reg)
                            OP_REDUCE: begin
                                sq_reg    <= mul_product;
                                state_reg <= ST_STEP;
                            end
                            OP_ACC: begin
                                acc_reg <= mul_product;
                                if (last_bit) begin
                                    res_reg   <= mul_product;
                                    state_reg <= ST_FINISH;
                                end else begin
                                    mul_a_reg     <= sq_reg;
                                    mul_b_reg     <= sq_reg;
                                    mul_start_reg <= 1'b1;
                                    op_reg        <= OP_SQUARE;
                                end
                            end
                            OP_SQUARE: begin
                                sq_reg    <= mul_product;
                                exp_reg   <= exp_reg >> 1;
                                idx_reg   <= idx_reg + 1'b1;
                                state_reg <= ST_STEP;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_FINISH: begin
                    // Hold the result until the output register has room.
                    if (out_free) begin
                        m_power_result_reg <= FIELD_WIDTH'(res_reg);
                        m_valid_reg        <= 1'b1;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_power_result = m_power_result_reg;

    `MX_ASSERT_IMP(a_done_when_waiting, aclk, aresetn, mul_status.done, state_reg == ST_MUL_WAIT)
    `MX_ASSERT_IMP(a_result_reduced, aclk, aresetn, state_reg == ST_FINISH && out_free, res_reg < n_reg || n_reg == '0)
    `MX_ASSERT_NXT(a_accept_leaves_idle, aclk, aresetn, s_valid && s_ready, state_reg != ST_IDLE)

endmodule

[bench/modular_exponentiation_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_exponentiation_core_tb
// Self-checking bench for the modular exponentiation core. Jobs of base,
// exponent and modulus are offered with random gaps in alternate stretches. Each accepted job is
// predicted with a square-and-multiply computed in 64-bit arithmetic, and
// every result word is compared in order against those predictions.
// ----------------------------------------------------------------------------
module modular_exponentiation_core_tb;
    import modexp_pkg::*;

    localparam int OPERAND_WIDTH = 32;
    localparam int STALL_LIMIT   = 40000;
    localparam int HOLD_CYCLES   = 6000;
    localparam int DRAIN_CYCLES  = 2200;
    localparam int RANDOM_JOBS   = 265;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [FIELD_WIDTH-1:0] s_base_value;
    logic [FIELD_WIDTH-1:0] s_exponent;
    logic [FIELD_WIDTH-1:0] s_modulus;
    logic                   m_valid;
    logic                   m_ready;
    logic [FIELD_WIDTH-1:0] m_power_result;

    // When clear, both sides run without idle cycles.
    bit idle_on;
    int stall_count;

    class modexp_scoreboard;
        logic [FIELD_WIDTH-1:0] expected_powers[$];
        int errors;

        function automatic logic [FIELD_WIDTH-1:0] power_mod(
            logic [FIELD_WIDTH-1:0] b, logic [FIELD_WIDTH-1:0] e,
            logic [FIELD_WIDTH-1:0] m);
            bit [63:0] mask;
            bit [63:0] x;
            bit [63:0] n;
            bit [63:0] acc;
            bit [63:0] sq;
            bit [63:0] ex;
            mask = (64'd1 << OPERAND_WIDTH) - 64'd1;
            x  = {32'd0, b} & mask;
            ex = {32'd0, e} & mask;
            n  = {32'd0, m} & mask;
            if (n == 64'd0)
                return '0;
            acc = 64'd1 % n;
            sq  = x % n;
            for (int i = 0; i < OPERAND_WIDTH; i++) begin
                if (ex[i])
                    acc = (acc * sq) % n;
                sq = (sq * sq) % n;
            end
            return acc[FIELD_WIDTH-1:0];
        endfunction

        function void note_job(logic [FIELD_WIDTH-1:0] b, logic [FIELD_WIDTH-1:0] e,
                               logic [FIELD_WIDTH-1:0] m);
            expected_powers.push_back(power_mod(b, e, m));
        endfunction

        function void check_result(logic [FIELD_WIDTH-1:0] got);
            logic [FIELD_WIDTH-1:0] want;
            if (expected_powers.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: power_result=%h", got);
                return;
            end
            want = expected_powers.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("power_result mismatch: expected %h, actual %h", want, got);
            end
        endfunction

        function int pending();
            return expected_powers.size();
        endfunction
    endclass

    modexp_scoreboard powers = new();

    modular_exponentiation_core #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_base_value  (s_base_value),
        .s_exponent    (s_exponent),
        .s_modulus     (s_modulus),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_power_result(m_power_result)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Random value confined to the low w bits.
    function automatic logic [31:0] low_bits(int w);
        if (w <= 0)
            return '0;
        return $urandom() >> (32 - w);
    endfunction

    task automatic send_job(input logic [31:0] b, input logic [31:0] e,
                            input logic [31:0] m);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_base_value <= b;
        s_exponent   <= e;
        s_modulus    <= m;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_random_job();
        logic [31:0] b;
        logic [31:0] e;
        logic [31:0] m;
        int          w;
        int          kind;
        kind = $urandom_range(0, 9);
        // Exponents take a random width of up to 32 bits.
        e = low_bits($urandom_range(0, 32));
        if (kind == 0) begin
            // Tiny modulus, where reductions wrap constantly.
            m = $urandom_range(1, 16);
            b = $urandom();
        end else begin
            w = $urandom_range(1, 32);
            m = low_bits(w) | (32'd1 << (w - 1));
            if (kind == 1) begin
                b = $urandom();
                e = $urandom();
            end else if (kind == 2) begin
                // Base no smaller than the modulus.
                b = m + low_bits($urandom_range(0, 31));
                if (b < m)
                    b = m;
            end else begin
                b = low_bits($urandom_range(0, 32));
            end
        end
        send_job(b, e, m);
    endtask

    // Input word accepted: record its expected power.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            powers.note_job(s_base_value, s_exponent, s_modulus);
    end

    // Result word accepted: compare against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            powers.check_result(m_power_result);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("modular_exponentiation_core test failed");
            $finish;
        end
    end

    // Result receiver. After a few dozen words it holds off for a long
    // stretch so that the core fills up and stops taking input words.
    initial begin
        int gap;
        int taken;
        taken = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (taken == 40) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                gap = idle_on ? $urandom_range(0, 7) : 0;
                if (gap != 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
            @(negedge aclk);
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_base_value = '0;
        s_exponent   = '0;
        s_modulus    = 32'd1;
        m_ready      = 1'b0;
        idle_on      = 1'b1;
        stall_count  = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Exponent zero gives one, except for a modulus of one.
        send_job(32'd5,          32'd0,          32'd7);
        send_job(32'd0,          32'd0,          32'd13);
        send_job(32'hFFFF_FFFF,  32'd0,          32'd1);
        send_job(32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd1);
        send_job(32'd0,          32'd5,          32'd13);
        send_job(32'd1,          32'hFFFF_FFFF,  32'hFFFF_FFFB);
        // Bases at or above the modulus are reduced first.
        send_job(32'd97,         32'd2,          32'd97);
        send_job(32'hFFFF_FFFF,  32'd3,          32'd1000);
        send_job(32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_job(32'hFFFF_FFFE,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_job(32'd2,          32'd31,         32'hFFFF_FFFF);
        send_job(32'h1234_5678,  32'd1,          32'd65537);
        send_job(32'd3,          32'h8000_0000,  32'd2);
        send_job(32'd3,          32'hFFFF_FFFA,  32'hFFFF_FFFB);
        send_job(32'd3,          32'hFFFF_FFFF,  32'h8000_0000);
        send_job(32'hAAAA_AAAA,  32'h5555_5555,  32'hAAAA_AAAB);
        send_job(32'h5555_5555,  32'hAAAA_AAAA,  32'h5555_5555);

        for (int i = 0; i < RANDOM_JOBS; i++) begin
            // Alternate stretches with and without idle cycles.
            if (i % 40 == 0)
                idle_on = (i % 80 != 0);
            send_random_job();
        end
        s_valid <= 1'b0;
        idle_on = 1'b1;

        while (powers.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (powers.errors == 0 && powers.pending() == 0) begin
            $display("modular_exponentiation_core test passed");
        end else begin
            $display("modular_exponentiation_core test failed");
        end
        $finish;
    end

endmodule
